>>> sv/lrupr_pkg.sv
package lrupr_pkg;

    // fixed field widths of the request and result items
    localparam int PID_W      = 5;
    localparam int PC_W       = 11;
    localparam int MAP_BITS   = 16;
    localparam int COUNT_W    = 5;
    localparam int PAGE_OUT_W = 4;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // stamps and search lanes
    localparam int STAMP_W = 32;
    localparam int LANES   = MAP_BITS;
    localparam int LANE_IW = 4;

    // oldest resident page found by the search tree
    typedef struct packed {
        logic               valid;
        logic [LANE_IW-1:0] idx;
    } search_res_t;

endpackage

>>> sv/lrupr_stamp_search.sv
module lrupr_stamp_search import lrupr_pkg::*; (
    input  logic                     aclk,
    input  logic [LANES*STAMP_W-1:0] row,
    input  logic [LANES-1:0]         lane_en,
    input  logic [STAMP_W-1:0]       tick,
    output search_res_t              result
);

    localparam int GROUPS = LANES / 4;

    typedef struct packed {
        logic               valid;
        logic [LANE_IW-1:0] idx;
        logic [STAMP_W-1:0] stamp;
    } cand_t;

    // left wins ties, so the lowest index survives
    function automatic cand_t pick(input cand_t a, input cand_t b);
        if (a.valid && (!b.valid || a.stamp <= b.stamp)) begin
            return a;
        end
        return b;
    endfunction

    cand_t lane [LANES];
    cand_t grp_reg [GROUPS];
    cand_t best_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane[i].stamp = row[i*STAMP_W +: STAMP_W];
            lane[i].idx   = LANE_IW'(i);
            lane[i].valid = lane_en[i] && (row[i*STAMP_W +: STAMP_W] < tick);
        end
    end

    // first level: four lanes per group
    always_ff @(posedge aclk) begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_reg[g] <= pick(pick(lane[4*g], lane[4*g+1]),
                               pick(lane[4*g+2], lane[4*g+3]));
        end
    end

    // second level: across the groups
    always_ff @(posedge aclk) begin
        best_reg <= pick(pick(grp_reg[0], grp_reg[1]), pick(grp_reg[2], grp_reg[3]));
    end

    assign result.valid = best_reg.valid;
    assign result.idx   = best_reg.idx;

endmodule

>>> sv/lru_page_replacement_unit.sv
// channel | dir | ports                    | contents
// s_      | in  | s_tvalid s_tready s_tdata | one access request, end_of_round on s_tlast
// m_      | out | m_tvalid m_tready m_tdata | one replacement decision per request
//
// a request, when the result register is free, steps through accept with the stamp
// row read, two levels of the min-search tree, then write-back of the stamped row;
// a new request is taken only after the last one's write-back
// reset clears the per-process row valid bits at once (no clearing pass) and sets
// the tick to one; a row never written reads as all-zero stamps
// write-back waits while the result register holds an untaken result; a new request
// is taken while that result waits
module lru_page_replacement_unit import lrupr_pkg::*; #(
    parameter int PROCESSES = 32,
    parameter int PAGES     = 16,
    parameter int PAGE_SIZE = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // process_id[4:0], program_counter[15:5], resident_map[31:16],
    // page_count[36:32], frame_free[37], zero fill[39:38]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,  // end_of_round
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // wanted_page[3:0], pagein_request[4], evict_valid[5], evict_page[9:6],
    // zero fill[15:10]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PROC_AW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PAGE_AW = $clog2(PAGES);
    localparam int ROW_W   = PAGES * STAMP_W;
    localparam int PID_N   = 2 ** PID_W;

    // page = pc / PAGE_SIZE by reciprocal multiply, exact for every 11-bit pc
    localparam int          PS_L   = $clog2(PAGE_SIZE);
    localparam int          SHIFT  = PC_W + PS_L;
    localparam logic [63:0] RECIP  = ((64'd1 << SHIFT) / PAGE_SIZE) + 64'd1;
    localparam int          RECIP_W = PC_W + 2;
    localparam int          Q_MAX  = ((2 ** PC_W) - 1) / PAGE_SIZE;
    localparam int          Q_W    = (Q_MAX > 0) ? $clog2(Q_MAX + 1) : 1;
    localparam int          Q_N    = 2 ** Q_W;
    localparam int          PROD_W = SHIFT + Q_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SRCH1 = 2'd1;
    localparam logic [1:0] ST_SRCH2 = 2'd2;
    localparam logic [1:0] ST_WB    = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [PROC_AW-1:0] proc_lut [PID_N];
    logic [PAGE_AW-1:0] page_lut [Q_N];

    // request fields
    logic [PROC_AW-1:0]  proc_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [MAP_BITS-1:0] map_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                free_reg;
    logic                eor_reg;

    logic [Q_W-1:0]     q_reg;
    logic [PAGE_AW-1:0] page_reg;
    logic [PROD_W-1:0]  prod;

    // stamp memory, one row per process
    logic [ROW_W-1:0]     stamp_mem [PROCESSES];
    logic [PROCESSES-1:0] row_vld_reg;
    logic [ROW_W-1:0]     rd_row_reg;
    logic                 rd_vld_reg;
    logic [ROW_W-1:0]     base_row;
    logic [ROW_W-1:0]     wr_row;
    logic [PROC_AW-1:0]   rd_addr;

    logic [STAMP_W-1:0] tick_reg, tick_next;

    logic [LANES*STAMP_W-1:0] srch_row;
    logic [LANES-1:0]         srch_en;
    search_res_t              srch_res;

    logic                  m_tvalid_reg;
    logic [PAGE_OUT_W-1:0] out_page_reg;
    logic                  out_pagein_reg;
    logic                  out_ev_valid_reg;
    logic [PAGE_OUT_W-1:0] out_ev_page_reg;

    logic in_fire, wb_fire, out_free;
    logic resident, ev_valid;

    // constant tables for the two modulo reductions
    for (genvar g = 0; g < PID_N; g++) begin : g_proc_lut
        assign proc_lut[g] = PROC_AW'(g % PROCESSES);
    end
    for (genvar g = 0; g < Q_N; g++) begin : g_page_lut
        assign page_lut[g] = PAGE_AW'(g % PAGES);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign wb_fire  = (state_reg == ST_WB) && out_free;
    assign rd_addr  = proc_lut[s_tdata[PID_W-1:0]];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_SRCH1;
                end
            end
            ST_SRCH1: state_next = ST_SRCH2;
            ST_SRCH2: state_next = ST_WB;
            ST_WB: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign tick_next = (wb_fire && eor_reg) ? tick_reg + STAMP_W'(1) : tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tick_reg    <= STAMP_W'(1);
            row_vld_reg <= '0;
        end else begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            if (wb_fire) begin
                row_vld_reg[proc_reg] <= 1'b1;
            end
        end
    end

    // capture the request and read its row
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            proc_reg   <= rd_addr;
            pc_reg     <= s_tdata[PID_W +: PC_W];
            map_reg    <= s_tdata[PID_W+PC_W +: MAP_BITS];
            count_reg  <= s_tdata[PID_W+PC_W+MAP_BITS +: COUNT_W];
            free_reg   <= s_tdata[PID_W+PC_W+MAP_BITS+COUNT_W];
            eor_reg    <= s_tlast;
            rd_row_reg <= stamp_mem[rd_addr];
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
        if (wb_fire) begin
            stamp_mem[proc_reg] <= wr_row;
        end
    end

    // wanted page: quotient in the first search cycle, modulo in the second
    assign prod = PROD_W'(pc_reg) * PROD_W'(RECIP[RECIP_W-1:0]);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SRCH1) begin
            q_reg <= prod[SHIFT +: Q_W];
        end
        if (state_reg == ST_SRCH2) begin
            page_reg <= page_lut[q_reg];
        end
    end

    // a row never written reads as zero stamps
    assign base_row = rd_vld_reg ? rd_row_reg : '0;

    always_comb begin
        for (int j = 0; j < PAGES; j++) begin
            if (page_reg == PAGE_AW'(j)) begin
                wr_row[j*STAMP_W +: STAMP_W] = tick_reg;
            end else begin
                wr_row[j*STAMP_W +: STAMP_W] = base_row[j*STAMP_W +: STAMP_W];
            end
        end
    end

    // search lanes: resident pages below page_count and below PAGES
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        if (j < PAGES) begin : g_used
            assign srch_row[j*STAMP_W +: STAMP_W] = base_row[j*STAMP_W +: STAMP_W];
            assign srch_en[j] = map_reg[j] && (COUNT_W'(j) < count_reg);
        end else begin : g_unused
            assign srch_row[j*STAMP_W +: STAMP_W] = '0;
            assign srch_en[j] = 1'b0;
        end
    end

    lrupr_stamp_search u_search (
        .aclk    (aclk),
        .row     (srch_row),
        .lane_en (srch_en),
        .tick    (tick_reg),
        .result  (srch_res)
    );

    assign resident = (32'(page_reg) < 32'(MAP_BITS)) && map_reg[LANE_IW'(page_reg)];
    assign ev_valid = !resident && !free_reg && srch_res.valid;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (wb_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wb_fire) begin
            out_page_reg     <= PAGE_OUT_W'(page_reg);
            out_pagein_reg   <= !resident;
            out_ev_valid_reg <= ev_valid;
            out_ev_page_reg  <= ev_valid ? srch_res.idx : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_ev_page_reg, out_ev_valid_reg, out_pagein_reg, out_page_reg};

    // an accepted request always moves on to the search
    a_accept_to_search: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg == ST_SRCH1)
        else $error("accepted request did not enter the search");

    // the tick only moves on a write-back that ends a round
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(tick_reg)) |-> $past(wb_fire && eor_reg))
        else $error("tick changed outside an end-of-round write-back");

    // an eviction only comes with a page-in request
    a_evict_needs_pagein: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_ev_valid_reg) |-> out_pagein_reg)
        else $error("eviction without page-in request");

    // no eviction reported when a frame was free
    a_no_evict_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_fire && free_reg) |=> !out_ev_valid_reg && (out_ev_page_reg == '0))
        else $error("eviction reported with a free frame");

endmodule

>>> tb/lru_decision_checker.sv
module lru_decision_checker import lrupr_pkg::*; #(
    parameter int PROCESSES = 32,
    parameter int PAGES     = 16,
    parameter int PAGE_SIZE = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatch_count,
    output int                   awaiting_results
);

    // request fields, process_id in the lowest bits
    typedef struct packed {
        logic                frame_free;
        logic [COUNT_W-1:0]  page_count;
        logic [MAP_BITS-1:0] resident_map;
        logic [PC_W-1:0]     program_counter;
        logic [PID_W-1:0]    process_id;
    } access_t;

    // decision fields, wanted_page in the lowest bits
    typedef struct packed {
        logic [PAGE_OUT_W-1:0] evict_page;
        logic                  evict_valid;
        logic                  pagein_request;
        logic [PAGE_OUT_W-1:0] wanted_page;
    } decision_t;

    localparam int ACCESS_W   = $bits(access_t);
    localparam int DECISION_W = $bits(decision_t);

    logic [STAMP_W-1:0] page_stamps [PROCESSES*PAGES];
    logic [STAMP_W-1:0] round_tick;
    decision_t          decision_q [$];
    decision_t          want;
    decision_t          got;

    // lru decision for one access, then stamp the wanted page
    function automatic decision_t lru_decide(input access_t acc, input logic round_end);
        int unsigned        proc;
        int unsigned        page;
        int unsigned        base;
        int unsigned        limit;
        int unsigned        i;
        logic [STAMP_W-1:0] oldest;
        decision_t          d;
        proc             = acc.process_id % PROCESSES;
        page             = (acc.program_counter / PAGE_SIZE) % PAGES;
        base             = proc * PAGES;
        d                = '0;
        d.wanted_page    = PAGE_OUT_W'(page);
        d.pagein_request = !(page < MAP_BITS && acc.resident_map[page]);
        if (d.pagein_request && !acc.frame_free) begin
            limit = acc.page_count;
            if (limit > PAGES) limit = PAGES;
            if (limit > MAP_BITS) limit = MAP_BITS;
            // strictly older than the tick, first index wins a tie
            oldest = round_tick;
            for (i = 0; i < limit; i++) begin
                if (acc.resident_map[i] && page_stamps[base + i] < oldest) begin
                    oldest        = page_stamps[base + i];
                    d.evict_page  = PAGE_OUT_W'(i);
                    d.evict_valid = 1'b1;
                end
            end
        end
        page_stamps[base + page] = round_tick;
        if (round_end) round_tick = round_tick + 1'b1;
        return d;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (page_stamps[k]) page_stamps[k] = '0;
            round_tick = 1;
            decision_q.delete();
            mismatch_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decision_q.push_back(lru_decide(access_t'(s_tdata[ACCESS_W-1:0]), s_tlast));
            end
            if (m_tvalid && m_tready) begin
                got = decision_t'(m_tdata[DECISION_W-1:0]);
                if (decision_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected decision %h with no request outstanding", got);
                    end
                end else begin
                    want = decision_q.pop_front();
                    if (got.wanted_page !== want.wanted_page ||
                        got.pagein_request !== want.pagein_request ||
                        got.evict_valid !== want.evict_valid ||
                        got.evict_page !== want.evict_page) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("decision mismatch: expected page %0d pagein %0b evict %0b/%0d",
                                     want.wanted_page, want.pagein_request,
                                     want.evict_valid, want.evict_page);
                            $display("  got page %0d pagein %0b evict %0b/%0d",
                                     got.wanted_page, got.pagein_request,
                                     got.evict_valid, got.evict_page);
                        end
                    end
                end
            end
        end
        awaiting_results = decision_q.size();
    end

endmodule

>>> tb/testbench.sv
module testbench;
    import lrupr_pkg::*;

    // no handshake on either side for this long means the block is stuck
    localparam int WATCHDOG_LIMIT = 2000;
    // long result-side hold-off so the block fills up and stalls its input
    localparam int LONG_HOLD      = 300;
    localparam int TOTAL_REQUESTS = 900;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int awaiting_results;
    int sent;
    int rounds;
    int idle_cycles;

    // idling switches, cleared for the final stretch of the run
    bit tx_gaps      = 1'b1;
    bit rx_stalls    = 1'b1;
    bit hold_off_req = 1'b0;

    always #5 aclk = ~aclk;

    lru_page_replacement_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // watches both channels, predicts every decision and counts mismatches
    lru_decision_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .awaiting_results (awaiting_results)
    );

    // offer one access request and hold it until the block takes it,
    // then maybe leave a random gap on the input side
    task automatic send_access(input logic [PID_W-1:0] pid, input logic [PC_W-1:0] pc,
                               input logic [MAP_BITS-1:0] map,
                               input logic [COUNT_W-1:0] cnt, input logic ff,
                               input logic eor);
        s_tdata  <= S_TDATA_W'({ff, cnt, map, pc, pid});
        s_tlast  <= eor;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (eor) rounds++;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // random request biased toward page misses with eviction searches
    task automatic random_access(input logic round_end);
        logic [PID_W-1:0]    pid;
        logic [PC_W-1:0]     pc;
        logic [MAP_BITS-1:0] map;
        logic [COUNT_W-1:0]  cnt;
        logic                ff;
        // a few hot processes so stamps get revisited across rounds
        pid = ($urandom_range(0, 7) == 0) ? PID_W'($urandom_range(0, 31))
                                          : PID_W'($urandom_range(0, 3));
        pc  = PC_W'($urandom_range(0, 2047));
        case ($urandom_range(0, 3))
            0: begin
                map = MAP_BITS'($urandom_range(0, 65535));
            end
            1: begin
                // sparse map
                map = MAP_BITS'($urandom_range(0, 65535) & $urandom_range(0, 65535));
            end
            2: begin
                // dense map
                map = ~MAP_BITS'($urandom_range(0, 65535) & $urandom_range(0, 65535));
            end
            default: begin
                // everything resident but the wanted page
                map = 16'hFFFF ^ (16'h0001 << pc[10:7]);
            end
        endcase
        cnt = ($urandom_range(0, 3) != 0) ? COUNT_W'(16) : COUNT_W'($urandom_range(0, 31));
        ff  = ($urandom_range(0, 3) == 0);
        send_access(pid, pc, map, cnt, ff, round_end);
    endtask

    // rounds of 1 to 8 accesses, the last one closing the round
    task automatic random_phase(input int target);
        int n;
        int k;
        while (sent < target) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) random_access(k == n - 1);
        end
    endtask

    // sender goes quiet until every outstanding decision has come back
    task automatic drain_decisions();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting_results != 0) @(posedge aclk);
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no request or decision moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // miss with an empty map: nothing to evict
        send_access(5'd0, 11'h000, 16'h0000, 5'd16, 1'b0, 1'b0);
        // top process, top page missing, all stamps zero: tie goes to page 0
        send_access(5'd31, 11'h7FF, 16'h7FFF, 5'd16, 1'b0, 1'b0);
        // same page now resident: a plain hit
        send_access(5'd31, 11'h7FF, 16'hFFFF, 5'd16, 1'b0, 1'b0);
        // hit at the end of page 0
        send_access(5'd0, 11'h07F, 16'h0001, 5'd16, 1'b0, 1'b0);
        // zero page count: search covers nothing
        send_access(5'd5, 11'h280, 16'hFFDF, 5'd0, 1'b0, 1'b0);
        // page count beyond the page limit gets clamped
        send_access(5'd5, 11'h300, 16'hFFBF, 5'd31, 1'b0, 1'b0);
        // free frame: page-in but no eviction
        send_access(5'd5, 11'h380, 16'h0000, 5'd16, 1'b1, 1'b0);
        // short search range that stops before the only resident page
        send_access(5'd6, 11'h000, 16'h0100, 5'd8, 1'b0, 1'b0);
        // only resident page stamped in this round: not older than the tick
        send_access(5'd2, 11'h180, 16'h0008, 5'd16, 1'b0, 1'b0);
        send_access(5'd2, 11'h280, 16'h0008, 5'd16, 1'b0, 1'b1);
        // next round: pages 3 and 5 share a stamp, lower index wins
        send_access(5'd2, 11'h300, 16'h0028, 5'd16, 1'b0, 1'b0);
        // refresh page 3, then page 5 is the least recently used
        send_access(5'd2, 11'h180, 16'h0068, 5'd16, 1'b0, 1'b1);
        send_access(5'd2, 11'h380, 16'h0068, 5'd16, 1'b0, 1'b0);
        // same search with page 5 outside the page count
        send_access(5'd2, 11'h400, 16'h0068, 5'd5, 1'b0, 1'b1);
        // mid-range fields
        send_access(5'd21, 11'h555, 16'hAAAA, 5'd10, 1'b0, 1'b0);
        send_access(5'd10, 11'h2AA, 16'h5555, 5'd21, 1'b0, 1'b1);

        random_phase(300);

        // fill the block: results held back while requests keep coming
        hold_off_req = 1'b1;
        tx_gaps      = 1'b0;
        repeat (12) random_access($urandom_range(0, 5) == 0);
        drain_decisions();
        tx_gaps = 1'b1;

        random_phase(500);
        // pause the sender until everything is back, then carry on
        drain_decisions();
        random_phase(720);

        // final stretch with no idling on either side
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        random_phase(TOTAL_REQUESTS);

        drain_decisions();
        repeat (20) @(posedge aclk);

        $display("covered %0d requests in %0d rounds: corner pages, tie-breaks, clamped searches",
                 sent, rounds);
        $display("random traffic with idle bursts, a %0d-cycle result hold-off, drained pauses",
                 LONG_HOLD);
        if (mismatch_count == 0 && awaiting_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
